@@ hdl/dfbt_pkg.sv @@
package dfbt_pkg;

	// Coefficient tables hold up to 64 taps; only the first 17 are non-zero
	localparam int unsigned CoefSlots = 64;
	localparam int unsigned SampleW   = 16;
	// Only the low 14 bits of a filter sum survive the times-4 wrap to 16 bits
	localparam int unsigned AccW      = 14;

	typedef logic signed [SampleW-1:0] sample_t;
	typedef logic [$clog2(CoefSlots)-1:0] coef_idx_t;
	typedef logic [AccW-1:0] acc_t;

	typedef struct packed {
		logic clear;
		logic mul_en;
	} mac_ctrl_t;

	function automatic sample_t lp_coef(coef_idx_t idx);
		sample_t c;
		case (idx)
			6'd0:    c = 16'sd652;
			6'd1:    c = 16'sd659;
			6'd2:    c = 16'sd665;
			6'd3:    c = 16'sd671;
			6'd4:    c = 16'sd675;
			6'd5:    c = 16'sd678;
			6'd6:    c = 16'sd681;
			6'd7:    c = 16'sd682;
			6'd8:    c = 16'sd683;
			6'd9:    c = 16'sd682;
			6'd10:   c = 16'sd681;
			6'd11:   c = 16'sd678;
			6'd12:   c = 16'sd675;
			6'd13:   c = 16'sd671;
			6'd14:   c = 16'sd665;
			6'd15:   c = 16'sd659;
			6'd16:   c = 16'sd652;
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic sample_t hp_coef(coef_idx_t idx);
		sample_t c;
		case (idx)
			6'd0:    c = -16'sd1130;
			6'd1:    c = -16'sd1439;
			6'd2:    c = -16'sd1738;
			6'd3:    c = -16'sd2015;
			6'd4:    c = -16'sd2258;
			6'd5:    c = -16'sd2458;
			6'd6:    c = -16'sd2608;
			6'd7:    c = -16'sd2700;
			6'd8:    c = 16'sd30038;
			6'd9:    c = -16'sd2700;
			6'd10:   c = -16'sd2608;
			6'd11:   c = -16'sd2458;
			6'd12:   c = -16'sd2258;
			6'd13:   c = -16'sd2015;
			6'd14:   c = -16'sd1738;
			6'd15:   c = -16'sd1439;
			6'd16:   c = -16'sd1129;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

@@ hdl/dfbt_cell.sv @@
module dfbt_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             rotate,
	input  dfbt_pkg::sample_t shift_in,
	input  dfbt_pkg::sample_t rotate_in,
	output dfbt_pkg::sample_t sample
);
	import dfbt_pkg::*;

	sample_t sample_q;

	// load ages the history by one word; rotate walks it past the multipliers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (load) begin
			sample_q <= shift_in;
		end else if (rotate) begin
			sample_q <= rotate_in;
		end
	end

	assign sample = sample_q;

endmodule

@@ hdl/dfbt_mac.sv @@
module dfbt_mac #(
	parameter bit HIGH = 1'b0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dfbt_pkg::mac_ctrl_t ctrl,
	input  dfbt_pkg::coef_idx_t idx,
	input  dfbt_pkg::sample_t   sample,
	output dfbt_pkg::acc_t      acc
);
	import dfbt_pkg::*;

	sample_t            coef;
	logic signed [31:0] prod_s1;
	logic               valid_s1;
	acc_t               acc_q;

	assign coef = HIGH ? hp_coef(idx) : lp_coef(idx);

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s1 <= sample * coef;
		end
	end

	// bits 28:15 are the floor of product / 2^15, wrapped to the accumulator width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			acc_q    <= '0;
		end else begin
			valid_s1 <= ctrl.mul_en;
			if (ctrl.clear) begin
				acc_q <= '0;
			end else if (valid_s1) begin
				acc_q <= acc_q + prod_s1[AccW+14:15];
			end
		end
	end

	assign acc = acc_q;

endmodule

@@ hdl/dual_fir_bass_treble_core.sv @@
// Bass and treble tone block on a mono sample stream.
// Input channel: mono_sample, right_sample and buttons move as one word when
// in_valid is high and in_stall is low. Output channel: left_out, right_out,
// bass_on, treble_on and halted move as one word under out_valid / out_stall.
// Each word, unless halted, pushes the mono sample into a TAPS-deep row of
// history cells; the row then rotates once per cycle past a shared low-pass
// and high-pass MAC pair, one tap per cycle. The word passes through ST_RUN
// for the taps, then ST_DRAIN and ST_DONE, where the result is written to the
// output register, and only then does the input reopen; the tap loop through
// the single MAC pair keeps a new word out until the last one is done.
// Once halted, a word skips the tap loop and is answered with zeros from ST_DONE.
// A finished result sits in the output register; the next word is accepted
// while it waits, but the block will not overwrite it until out_stall drops.
// Reset clears the history to zero, both tone enables, the button edge memory
// and the halt flag; no result is pending after reset.
module dual_fir_bass_treble_core #(
	parameter int unsigned TAPS = 17
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  dfbt_pkg::sample_t mono_sample,
	input  dfbt_pkg::sample_t right_sample,
	input  logic [1:0]        buttons,
	output logic              out_valid,
	input  logic              out_stall,
	output dfbt_pkg::sample_t left_out,
	output dfbt_pkg::sample_t right_out,
	output logic              bass_on,
	output logic              treble_on,
	output logic              halted
);
	import dfbt_pkg::*;

	localparam int unsigned KW = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam logic [KW-1:0] LastTap = KW'(TAPS - 1);

	localparam logic [1:0] BtnNone   = 2'd0;
	localparam logic [1:0] BtnBass   = 2'd1;
	localparam logic [1:0] BtnTreble = 2'd2;
	localparam logic [1:0] BtnBoth   = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t    state_q;
	logic [KW-1:0] tap_q;
	logic      bass_en_q;
	logic      treble_en_q;
	logic [1:0] prev_btn_q;
	logic      stopped_q;
	logic      item_bass_q;
	logic      item_treble_q;
	logic      item_halted_q;
	sample_t   item_right_q;
	logic      out_valid_q;
	sample_t   left_q;
	sample_t   right_q;
	logic      bass_out_q;
	logic      treble_out_q;
	logic      halted_q;

	logic      accept;
	logic      load;
	logic      rotate;
	mac_ctrl_t ctrl;
	coef_idx_t idx;
	acc_t      lp_acc;
	acc_t      hp_acc;
	acc_t      tone_sum;
	sample_t   hist [TAPS];

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign load     = accept && !stopped_q;
	assign rotate   = (state_q == ST_RUN);

	assign ctrl.clear  = load;
	assign ctrl.mul_en = rotate;
	assign idx         = coef_idx_t'(tap_q);

	for (genvar i = 0; i < TAPS; i++) begin : g_cell
		sample_t shift_in;
		if (i == 0) begin : g_head
			assign shift_in = mono_sample;
		end else begin : g_body
			assign shift_in = hist[i-1];
		end
		dfbt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.load      (load),
			.rotate    (rotate),
			.shift_in  (shift_in),
			.rotate_in (hist[(i + 1) % TAPS]),
			.sample    (hist[i])
		);
	end

	dfbt_mac #(.HIGH(1'b0)) u_lp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.idx    (idx),
		.sample (hist[0]),
		.acc    (lp_acc)
	);

	dfbt_mac #(.HIGH(1'b1)) u_hp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.idx    (idx),
		.sample (hist[0]),
		.acc    (hp_acc)
	);

	assign tone_sum = (item_bass_q ? lp_acc : '0) + (item_treble_q ? hp_acc : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			tap_q         <= '0;
			bass_en_q     <= 1'b0;
			treble_en_q   <= 1'b0;
			prev_btn_q    <= '0;
			stopped_q     <= 1'b0;
			item_bass_q   <= 1'b0;
			item_treble_q <= 1'b0;
			item_halted_q <= 1'b0;
			item_right_q  <= '0;
			out_valid_q   <= 1'b0;
			left_q        <= '0;
			right_q       <= '0;
			bass_out_q    <= 1'b0;
			treble_out_q  <= 1'b0;
			halted_q      <= 1'b0;
		end else begin
			// in ST_DONE the output register is handled below
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					tap_q <= '0;
					if (accept) begin
						if (stopped_q) begin
							// halted: answer with zeros, leave all state frozen
							item_bass_q   <= 1'b0;
							item_treble_q <= 1'b0;
							item_halted_q <= 1'b1;
							item_right_q  <= '0;
							state_q       <= ST_DONE;
						end else begin
							// the word uses the enables as they stand before its buttons
							item_bass_q   <= bass_en_q;
							item_treble_q <= treble_en_q;
							item_halted_q <= 1'b0;
							item_right_q  <= right_sample;
							if (buttons == BtnBoth) begin
								stopped_q <= 1'b1;
							end else begin
								if (buttons == BtnBass && prev_btn_q == BtnNone) begin
									bass_en_q <= !bass_en_q;
								end
								if (buttons == BtnTreble && prev_btn_q == BtnNone) begin
									treble_en_q <= !treble_en_q;
								end
								prev_btn_q <= buttons;
							end
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (tap_q == LastTap) begin
						state_q <= ST_DRAIN;
					end else begin
						tap_q <= tap_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the previous result has been taken
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						left_q       <= {tone_sum, 2'b00};
						right_q      <= item_right_q;
						bass_out_q   <= item_bass_q;
						treble_out_q <= item_treble_q;
						halted_q     <= item_halted_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign left_out  = left_q;
	assign right_out = right_q;
	assign bass_on   = bass_out_q;
	assign treble_on = treble_out_q;
	assign halted    = halted_q;

endmodule

@@ bench/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dfbt_pkg::*;

	localparam int TAP_COUNT   = 17;
	localparam int CYCLE_LIMIT = 600000;
	localparam int TAIL_CYCLES = 60;

	localparam logic [1:0] BTN_NONE   = 2'd0;
	localparam logic [1:0] BTN_BASS   = 2'd1;
	localparam logic [1:0] BTN_TREBLE = 2'd2;
	localparam logic [1:0] BTN_BOTH   = 2'd3;

	localparam logic signed [15:0] LOWPASS_TAPS [TAP_COUNT] = '{
		16'sd652, 16'sd659, 16'sd665, 16'sd671, 16'sd675, 16'sd678, 16'sd681, 16'sd682,
		16'sd683, 16'sd682, 16'sd681, 16'sd678, 16'sd675, 16'sd671, 16'sd665, 16'sd659,
		16'sd652
	};
	localparam logic signed [15:0] HIGHPASS_TAPS [TAP_COUNT] = '{
		-16'sd1130, -16'sd1439, -16'sd1738, -16'sd2015, -16'sd2258, -16'sd2458,
		-16'sd2608, -16'sd2700, 16'sd30038, -16'sd2700, -16'sd2608, -16'sd2458,
		-16'sd2258, -16'sd2015, -16'sd1738, -16'sd1439, -16'sd1129
	};

	typedef struct packed {
		sample_t left;
		sample_t right;
		logic    bass;
		logic    treble;
		logic    halt;
	} tone_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	sample_t    mono_sample = '0;
	sample_t    right_sample = '0;
	logic [1:0] buttons = BTN_NONE;
	logic       out_valid;
	logic       out_stall = 1'b0;
	sample_t    left_out;
	sample_t    right_out;
	logic       bass_on;
	logic       treble_on;
	logic       halted;

	// predictor state
	sample_t     tap_line [TAP_COUNT];
	int          tap_pos;
	logic        bass_en;
	logic        treble_en;
	logic [1:0]  last_buttons;
	logic        frozen;

	tone_word_t  pending_words [$];
	int          errors = 0;
	int          cycle_count = 0;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int          hold_request = 0;
	int          hold_left = 0;

	dual_fir_bass_treble_core #(.TAPS(TAP_COUNT)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mono_sample  (mono_sample),
		.right_sample (right_sample),
		.buttons      (buttons),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.left_out     (left_out),
		.right_out    (right_out),
		.bass_on      (bass_on),
		.treble_on    (treble_on),
		.halted       (halted)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	function automatic tone_word_t tone_predict(sample_t mono, sample_t right, logic [1:0] btn);
		tone_word_t w;
		int j, idx, s, lp_acc, hp_acc;
		logic [15:0] lp16, hp16, sum16;
		w = '0;
		if (frozen) begin
			w.halt = 1'b1;
			return w;
		end
		tap_line[tap_pos] = mono;
		lp_acc = 0;
		hp_acc = 0;
		for (j = 0; j < TAP_COUNT; j++) begin
			idx = (tap_pos + TAP_COUNT - j) % TAP_COUNT;
			s = tap_line[idx];
			// floor of each product over 2^15
			lp_acc += (s * int'(LOWPASS_TAPS[j])) >>> 15;
			hp_acc += (s * int'(HIGHPASS_TAPS[j])) >>> 15;
		end
		lp16 = 16'(lp_acc * 4);
		hp16 = 16'(hp_acc * 4);
		sum16 = '0;
		if (bass_en)
			sum16 += lp16;
		if (treble_en)
			sum16 += hp16;
		w.left   = sum16;
		w.right  = right;
		w.bass   = bass_en;
		w.treble = treble_en;
		tap_pos = (tap_pos + 1) % TAP_COUNT;
		// toggle only on a press from released
		if (btn == BTN_BASS && last_buttons == BTN_NONE)
			bass_en = ~bass_en;
		if (btn == BTN_TREBLE && last_buttons == BTN_NONE)
			treble_en = ~treble_en;
		if (btn == BTN_BOTH)
			frozen = 1'b1;
		else
			last_buttons = btn;
		return w;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		tone_word_t w;
		if (out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual left %0d right %0d",
					$time, left_out, right_out);
				errors++;
			end else begin
				w = pending_words.pop_front();
				check_field("left_out", w.left, left_out);
				check_field("right_out", w.right, right_out);
				check_field("bass_on", w.bass, bass_on);
				check_field("treble_on", w.treble, treble_on);
				check_field("halted", w.halt, halted);
			end
		end
	end

	// receiver: random stall, or a long hold when asked
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	task automatic send_word(sample_t mono, sample_t right, logic [1:0] btn);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		mono_sample  <= mono;
		right_sample <= right;
		buttons      <= btn;
		do
			@(posedge clk);
		while (in_stall);
		pending_words.push_back(tone_predict(mono, right, btn));
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0:       return 16'sh7fff;
			1:       return 16'sh8000;
			2:       return sample_t'($urandom_range(0, 64) - 32);
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic logic [1:0] pick_buttons();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return BTN_NONE;
		else if (r < 85)
			return BTN_BASS;
		return BTN_TREBLE;
	endfunction

	task automatic test_extremes_and_toggles();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_word(16'sh7fff, 16'sh7fff, BTN_BASS);
		send_word(16'sh8000, 16'sh8000, BTN_NONE);
		send_word(16'sh7fff, 16'sh0000, BTN_TREBLE);
		// held button: no second toggle
		send_word(16'sh8000, 16'shffff, BTN_TREBLE);
		// bass straight after treble: no toggle
		send_word(16'shffff, 16'sh0001, BTN_BASS);
		send_word(16'sh0001, 16'sh5555, BTN_NONE);
		send_word(16'sh7fff, 16'shaaaa, BTN_NONE);
		send_word(16'sh8000, 16'sh0000, BTN_NONE);
		send_word(16'sh7fff, 16'sh1234, BTN_NONE);
		send_word(16'sh8000, 16'shedcb, BTN_NONE);
		send_word(16'sh7fff, 16'sh7fff, BTN_BASS);
		send_word(16'sh0000, 16'sh8000, BTN_NONE);
		send_word(16'sh8000, 16'sh0f0f, BTN_TREBLE);
		send_word(16'sh0000, 16'shf0f0, BTN_NONE);
		send_word(16'sh7fff, 16'sh0000, BTN_NONE);
		wait_drain();
	endtask

	task automatic test_random_stream(int count, int tx_pct, int rx_pct);
		int k;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (k = 0; k < count; k++)
			send_word(pick_sample(), sample_t'($urandom), pick_buttons());
		wait_drain();
	endtask

	task automatic test_backpressure();
		int k;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_request = 300;
		// keep offering while the output is held so the input backs up
		for (k = 0; k < 12; k++)
			send_word(pick_sample(), sample_t'($urandom), pick_buttons());
		// pause until every word has come out
		wait_drain();
		for (k = 0; k < 6; k++)
			send_word(pick_sample(), sample_t'($urandom), pick_buttons());
		wait_drain();
	endtask

	task automatic test_halt();
		int k;
		tx_idle_pct = 20;
		rx_idle_pct = 20;
		send_word(pick_sample(), sample_t'($urandom), BTN_NONE);
		send_word(16'sh4000, 16'sh2222, BTN_BOTH);
		// inputs ignored from here on
		send_word(16'sh7fff, 16'sh7fff, BTN_BASS);
		send_word(16'sh8000, 16'sh8000, BTN_TREBLE);
		send_word(16'sh1111, 16'sh3333, BTN_BOTH);
		for (k = 0; k < 20; k++)
			send_word(sample_t'($urandom), sample_t'($urandom), 2'($urandom));
		wait_drain();
	endtask

	initial begin
		int k;
		for (k = 0; k < TAP_COUNT; k++)
			tap_line[k] = '0;
		tap_pos      = 0;
		bass_en      = 1'b0;
		treble_en    = 1'b0;
		last_buttons = BTN_NONE;
		frozen       = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes_and_toggles();
		test_random_stream(200, 38, 61);
		test_random_stream(200, 61, 38);
		test_random_stream(200, 0, 0);
		test_backpressure();
		test_halt();

		rx_idle_pct = 0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
